// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RPCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpct assertion failed");

// next-cycle implication
`define RPCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpct assertion failed");

`endif

// ===== rtl/rpct_pkg.sv =====
// shared constants, widths and arithmetic helpers of the rotated pole transform
// no dependencies
package rpct_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam int LON_IN_W  = 25;
  localparam int LAT_IN_W  = 24;
  localparam int LON_OUT_W = 27;
  localparam int LAT_OUT_W = 24;
  localparam int POLE_LON_W = 26;
  localparam int POLE_LAT_W = 24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 26;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_LON = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_LAT = 1'b1;

  localparam logic signed [POLE_LON_W-1:0] POLE_LON_RST = -26'sd10616832;
  localparam logic signed [POLE_LAT_W-1:0] POLE_LAT_RST = 24'sd2572288;

  localparam int DW    = 28;
  localparam int ANG_W = 25;
  localparam int QW    = 34;
  localparam int ZW    = 64;
  localparam int SQ_NW = 61;
  localparam int SQ_RW = 31;

  localparam int DEG90  = 5898240;
  localparam int DEG180 = 11796480;
  localparam int DEG360 = 23592960;

  localparam longint KINV_Q30 = 64'sd652032874;
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint PI_Q60   = 64'sh3243F6A8885A308D;
  localparam longint D2R      = 64'sd307041569098;
  localparam longint R2D      = 64'sd60078979;

  localparam logic signed [2*QW-1:0] ROUND30 = (2*QW)'(64'sd1 <<< 29);

  // quotient of a non-negative value, evaluated at elaboration only
  function automatic longint quot(input longint num, input longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    longint sum;
    longint term;
    int k;
    sum = 0;
    if (i == 0) begin
      sum = PI_Q60 >>> 2;
    end else begin
      for (k = 0; i * (2 * k + 1) < 61; k++) begin
        term = quot((64'sd1 <<< 60) >>> (i * (2 * k + 1)), longint'(2 * k + 1));
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic signed [QW-1:0] mul30(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    p = p + ROUND30;
    return p[QW+29:30];
  endfunction

endpackage

// ===== rtl/rpct_if.sv =====
// valid/ready channel interfaces for input and result transactions
// depends on rpct_pkg
interface rpct_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  forward;
  logic signed [rpct_pkg::LON_IN_W-1:0]  lon_in;
  logic signed [rpct_pkg::LAT_IN_W-1:0]  lat_in;

  modport source (output valid, forward, lon_in, lat_in, input ready);
  modport sink (input valid, forward, lon_in, lat_in, output ready);
endinterface

interface rpct_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rpct_pkg::LON_OUT_W-1:0] lon_out;
  logic signed [rpct_pkg::LAT_OUT_W-1:0] lat_out;

  modport source (output valid, lon_out, lat_out, input ready);
  modport sink (input valid, lon_out, lat_out, output ready);
endinterface

// ===== rtl/rpct_sincos.sv =====
// pipelined sine/cosine: angle reduction, degree to radian, cordic rotation
// depends on rpct_pkg
module rpct_sincos #(
  parameter int STEPS = rpct_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [rpct_pkg::DW-1:0]   deg_i,
  output logic                             valid_o,
  output logic signed [rpct_pkg::QW-1:0]   sin_o,
  output logic signed [rpct_pkg::QW-1:0]   cos_o
);
  import rpct_pkg::*;

  localparam logic signed [DW:0] P180 = (DW+1)'(DEG180);
  localparam logic signed [DW:0] N180 = (DW+1)'(-DEG180);
  localparam logic signed [DW:0] P90  = (DW+1)'(DEG90);
  localparam logic signed [DW:0] N90  = (DW+1)'(-DEG90);
  localparam logic signed [20:0] RAD_HI = 21'(D2R >>> 20);
  localparam logic signed [20:0] RAD_LO = 21'(D2R & 64'sh00000000000FFFFF);

  logic [STEPS+3:0]          v_q;
  logic signed [DW:0]        red_d;
  logic signed [DW:0]        fold_d;
  logic                      neg_d;
  logic signed [ANG_W-1:0]   a_q;
  logic                      neg_a_q;
  logic signed [45:0]        hi_q;
  logic signed [45:0]        lo_q;
  logic                      neg_b_q;
  logic signed [QW-1:0]      x_q [0:STEPS];
  logic signed [QW-1:0]      y_q [0:STEPS];
  logic signed [ZW-1:0]      z_q [0:STEPS];
  logic                      neg_q [0:STEPS];
  logic signed [QW-1:0]      sin_q;
  logic signed [QW-1:0]      cos_q;

  // reduce into [-180,180) then fold into [-90,90]
  always_comb begin
    logic signed [DW:0] wide;
    logic signed [DW:0] t;
    wide  = (DW+1)'(deg_i);
    red_d = wide;
    for (int k = -3; k <= 3; k++) begin
      t = wide - (DW+1)'(k * DEG360);
      if (t >= N180 && t < P180) red_d = t;
    end
    neg_d = 1'b1;
    if (red_d > P90) begin
      fold_d = red_d - P180;
    end else if (red_d < N90) begin
      fold_d = red_d + P180;
    end else begin
      fold_d = red_d;
      neg_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STEPS+2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= fold_d[ANG_W-1:0];
      neg_a_q  <= neg_d;
      hi_q     <= a_q * RAD_HI;
      lo_q     <= a_q * RAD_LO;
      neg_b_q  <= neg_a_q;
      x_q[0]   <= QW'(KINV_Q30);
      y_q[0]   <= '0;
      z_q[0]   <= (ZW'(hi_q) <<< 20) + ZW'(lo_q);
      neg_q[0] <= neg_b_q;
      sin_q    <= neg_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
      cos_q    <= neg_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATN = atan_entry(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATN;
        end
      end
    end
  end

  assign valid_o = v_q[STEPS+3];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

// ===== rtl/rpct_isqrt.sv =====
// pipelined integer square root, one result bit per stage, with sideband
// depends on rpct_pkg
module rpct_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rpct_pkg::SQ_NW-1:0]    n_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [rpct_pkg::SQ_RW-1:0]    root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import rpct_pkg::*;

  localparam int STG = SQ_RW;
  localparam int TW  = SQ_NW + 2;

  logic [STG:0]        v_q;
  logic [SQ_NW-1:0]    rem_q  [0:STG];
  logic [SQ_RW-1:0]    root_q [0:STG];
  logic [SIDE_W-1:0]   side_q [0:STG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STG-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= n_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < STG; j++) begin : g_bit
    localparam int K = STG - 1 - j;
    logic [TW-1:0] trial;
    logic          fits;
    assign trial = (TW'(root_q[j]) << (K + 1)) + (TW'(1) << (2 * K));
    assign fits  = TW'(rem_q[j]) >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j+1] <= side_q[j];
        if (fits) begin
          rem_q[j+1]  <= rem_q[j] - trial[SQ_NW-1:0];
          root_q[j+1] <= root_q[j] | (SQ_RW'(1) << K);
        end else begin
          rem_q[j+1]  <= rem_q[j];
          root_q[j+1] <= root_q[j];
        end
      end
    end
  end

  assign valid_o = v_q[STG];
  assign root_o  = root_q[STG];
  assign side_o  = side_q[STG];

endmodule

// ===== rtl/rpct_atan2.sv =====
// pipelined atan2 by cordic vectoring, then radians to degrees, with sideband
// depends on rpct_pkg
module rpct_atan2 #(
  parameter int STEPS  = rpct_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [rpct_pkg::QW-1:0]  y_i,
  input  logic signed [rpct_pkg::QW-1:0]  x_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic signed [rpct_pkg::DW-1:0]  deg_o,
  output logic [SIDE_W-1:0]               side_o
);
  import rpct_pkg::*;

  localparam logic signed [26:0] R2D_C = 27'(R2D);
  localparam logic signed [65:0] RND37 = 66'(64'sd1 <<< 37);

  logic [STEPS+2:0]        v_q;
  logic signed [QW-1:0]    x_q [0:STEPS];
  logic signed [QW-1:0]    y_q [0:STEPS];
  logic signed [ZW-1:0]    z_q [0:STEPS];
  logic [SIDE_W-1:0]       side_q [0:STEPS+2];
  logic signed [65:0]      prod_q;
  logic signed [65:0]      rnd;
  logic signed [DW-1:0]    deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STEPS+1:0], valid_i};
    end
  end

  assign rnd = prod_q + RND37;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? ZW'(PI_Q60) : -ZW'(PI_Q60);
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
      prod_q           <= (z_q[STEPS] >>> 26) * R2D_C;
      side_q[STEPS+1]  <= side_q[STEPS];
      deg_q            <= rnd[DW+37:38];
      side_q[STEPS+2]  <= side_q[STEPS+1];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATN = atan_entry(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATN;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATN;
        end
      end
    end
  end

  assign valid_o = v_q[STEPS+2];
  assign deg_o   = deg_q;
  assign side_o  = side_q[STEPS+2];

endmodule

// ===== rtl/rotated_pole_coordinate_transform_unit.sv =====
// top level: rotated pole transform pipeline with pole registers and output skid
// pipeline depth is set by the two cordic chains and the 31-stage square root;
// one transaction per cycle sustained while the output skid is empty
// reset clears all valid bits and the skid, and loads the default pole
// depends on rpct_pkg, rpct_if, rpct_sincos, rpct_isqrt, rpct_atan2
module rotated_pole_coordinate_transform_unit #(
  parameter int CORDIC_STEPS = rpct_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rpct_in_if.sink                            in_ch,
  rpct_out_if.source                         out_ch,
  input  logic                               cfg_we_i,
  input  logic [rpct_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rpct_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rpct_pkg::*;

  localparam int SC_LAT = CORDIC_STEPS + 4;
  localparam int SIDE_W = 1 + 3 * QW;
  localparam logic signed [QW:0]  ONE_P = (QW+1)'(ONE_Q30);
  localparam logic signed [QW:0]  ONE_N = (QW+1)'(-ONE_Q30);
  localparam logic [61:0]         ONE60 = 62'(1) << 60;

  logic                          en;
  logic signed [POLE_LON_W-1:0]  pole_lon_q;
  logic signed [POLE_LAT_W-1:0]  pole_lat_q;

  // input stage
  logic                          in_v_q;
  logic                          fwd_i_q;
  logic signed [LON_IN_W-1:0]    lon_i_q;
  logic signed [LAT_IN_W-1:0]    lat_i_q;
  logic signed [DW-1:0]          l_deg;
  logic signed [DW-1:0]          d_raw;
  logic signed [DW-1:0]          d_deg;
  logic signed [DW-1:0]          lon_ang;

  // sine/cosine results
  logic                          sc_v;
  logic signed [QW-1:0]          sl, cl, sp, cp, sd, cd;
  logic                          fl_q [0:SC_LAT-1];

  // product stages
  logic                          p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  logic signed [QW-1:0]          cdsp1_q, clsd1_q, clcd1_q, yy1_q, spsd1_q, cp1_q;
  logic                          fwd1_q, fwd2_q, fwd3_q, fwd4_q, fwd5_q;
  logic signed [QW-1:0]          t1_q, t2_q, cdsp2_q, spsd2_q, yy2_q;
  logic signed [QW:0]            v_raw;
  logic signed [31:0]            v_d;
  logic signed [31:0]            v3_q, v4_q, v5_q;
  logic signed [QW-1:0]          xx3_q, yy3_q, xx4_q, yy4_q, xx5_q, yy5_q;
  logic signed [61:0]            vsq;
  logic [61:0]                   vsq4_q;
  logic [SQ_NW-1:0]              n5_q;

  // square root and atan2
  logic                          sq_v;
  logic [SQ_RW-1:0]              root;
  logic [SIDE_W-1:0]             sq_side;
  logic                          s_fwd;
  logic signed [QW-1:0]          s_v, s_yy, s_xx;
  logic                          lat_v;
  logic signed [DW-1:0]          lat_deg;
  logic signed [DW-1:0]          lon_deg;
  logic                          lon_fwd;

  // output register and skid
  logic                          push;
  logic                          take;
  logic signed [DW:0]            lon_off;
  logic signed [DW:0]            lon_sum;
  logic signed [LON_OUT_W-1:0]   res_lon;
  logic signed [LAT_OUT_W-1:0]   res_lat;
  logic                          out_v_q, sk_v_q;
  logic signed [LON_OUT_W-1:0]   out_lon_q, sk_lon_q;
  logic signed [LAT_OUT_W-1:0]   out_lat_q, sk_lat_q;

  assign en          = !sk_v_q;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_lon_q <= POLE_LON_RST;
      pole_lat_q <= POLE_LAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLE_LON: pole_lon_q <= cfg_data_i[POLE_LON_W-1:0];
        REG_POLE_LAT: pole_lat_q <= cfg_data_i[POLE_LAT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_ch.valid;
      p1_v_q <= sc_v;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_ch.valid) begin
      fwd_i_q <= in_ch.forward;
      lon_i_q <= in_ch.lon_in;
      lat_i_q <= in_ch.lat_in;
    end
  end

  assign l_deg   = DW'(lon_i_q) - DW'(DEG180) - DW'(pole_lon_q);
  assign d_raw   = DW'(pole_lat_q) - DW'(DEG90);
  assign d_deg   = fwd_i_q ? d_raw : -d_raw;
  assign lon_ang = fwd_i_q ? DW'(lon_i_q) : l_deg;

  rpct_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_v_q), .deg_i(lon_ang),
    .valid_o(sc_v), .sin_o(sl), .cos_o(cl)
  );

  rpct_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_v_q), .deg_i(DW'(lat_i_q)),
    .valid_o(), .sin_o(sp), .cos_o(cp)
  );

  rpct_sincos #(.STEPS(CORDIC_STEPS)) u_sc_off (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_v_q), .deg_i(d_deg),
    .valid_o(), .sin_o(sd), .cos_o(cd)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fwd_i_q;
      for (int j = 1; j < SC_LAT; j++) begin
        fl_q[j] <= fl_q[j-1];
      end
    end
  end

  always_comb begin
    v_raw = (QW+1)'(cdsp2_q) - (QW+1)'(t1_q);
    if (v_raw > ONE_P) v_d = 32'(ONE_P);
    else if (v_raw < ONE_N) v_d = 32'(ONE_N);
    else v_d = v_raw[31:0];
  end

  assign vsq = v3_q * v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cdsp1_q <= mul30(cd, sp);
      clsd1_q <= mul30(cl, sd);
      clcd1_q <= mul30(cl, cd);
      yy1_q   <= mul30(sl, cp);
      spsd1_q <= mul30(sp, sd);
      cp1_q   <= cp;
      fwd1_q  <= fl_q[SC_LAT-1];

      t1_q    <= mul30(clsd1_q, cp1_q);
      t2_q    <= mul30(clcd1_q, cp1_q);
      cdsp2_q <= cdsp1_q;
      spsd2_q <= spsd1_q;
      yy2_q   <= yy1_q;
      fwd2_q  <= fwd1_q;

      v3_q    <= v_d;
      xx3_q   <= spsd2_q + t2_q;
      yy3_q   <= yy2_q;
      fwd3_q  <= fwd2_q;

      vsq4_q  <= vsq;
      v4_q    <= v3_q;
      xx4_q   <= xx3_q;
      yy4_q   <= yy3_q;
      fwd4_q  <= fwd3_q;

      n5_q    <= SQ_NW'(ONE60 - vsq4_q);
      v5_q    <= v4_q;
      xx5_q   <= xx4_q;
      yy5_q   <= yy4_q;
      fwd5_q  <= fwd4_q;
    end
  end

  rpct_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p5_v_q), .n_i(n5_q),
    .side_i({fwd5_q, QW'(v5_q), yy5_q, xx5_q}),
    .valid_o(sq_v), .root_o(root), .side_o(sq_side)
  );

  assign s_fwd = sq_side[SIDE_W-1];
  assign s_v   = sq_side[3*QW-1:2*QW];
  assign s_yy  = sq_side[2*QW-1:QW];
  assign s_xx  = sq_side[QW-1:0];

  rpct_atan2 #(.STEPS(CORDIC_STEPS), .SIDE_W(1)) u_at_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v),
    .y_i(s_v), .x_i(QW'(root)), .side_i(s_fwd),
    .valid_o(lat_v), .deg_o(lat_deg), .side_o()
  );

  rpct_atan2 #(.STEPS(CORDIC_STEPS), .SIDE_W(1)) u_at_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v),
    .y_i(s_yy), .x_i(s_xx), .side_i(s_fwd),
    .valid_o(), .deg_o(lon_deg), .side_o(lon_fwd)
  );

  assign lon_off = lon_fwd ? ((DW+1)'(DEG180) + (DW+1)'(pole_lon_q)) : '0;
  assign lon_sum = (DW+1)'(lon_deg) + lon_off;
  assign res_lon = lon_sum[LON_OUT_W-1:0];
  assign res_lat = lat_deg[LAT_OUT_W-1:0];

  assign push = lat_v & en;
  assign take = out_v_q & out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (take) sk_v_q <= 1'b0;
    end else if (push) begin
      if (!out_v_q || take) out_v_q <= 1'b1;
      else sk_v_q <= 1'b1;
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (take) begin
        out_lon_q <= sk_lon_q;
        out_lat_q <= sk_lat_q;
      end
    end else if (push) begin
      if (!out_v_q || take) begin
        out_lon_q <= res_lon;
        out_lat_q <= res_lat;
      end else begin
        sk_lon_q <= res_lon;
        sk_lat_q <= res_lat;
      end
    end
  end

  assign out_ch.valid   = out_v_q;
  assign out_ch.lon_out = out_lon_q;
  assign out_ch.lat_out = out_lat_q;

endmodule

// ===== rtl/rpct_checker.sv =====
// port-level assertions for the rotated pole transform, bound to the top level
// depends on rpct_pkg, assert_macros.svh and rotated_pole_coordinate_transform_unit
`include "assert_macros.svh"

module rpct_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [rpct_pkg::LON_OUT_W-1:0] lon_out_i,
  input logic signed [rpct_pkg::LAT_OUT_W-1:0] lat_out_i
);

  `RPCT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `RPCT_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(lon_out_i) && $stable(lat_out_i))
  `RPCT_ASSERT_NOW(a_stall_has_result, !in_ready_i, out_valid_i)
  `RPCT_ASSERT_NEXT(a_drain_reopens, out_valid_i && out_ready_i && !in_ready_i, in_ready_i)

endmodule

bind rotated_pole_coordinate_transform_unit rpct_checker u_rpct_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_ch.valid),
  .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .lon_out_i(out_ch.lon_out),
  .lat_out_i(out_ch.lat_out)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for rotated_pole_coordinate_transform_unit
// a scoreboard class predicts each transaction and checks the results in order
// depends on rpct_pkg, rpct_if and the rtl of the unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpct_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [LON_OUT_W-1:0] lon;
    logic [LAT_OUT_W-1:0] lat;
  } point_t;

  class transform_scoreboard;
    longint pole_lon;
    longint pole_lat;
    longint atan_tab[STEPS];
    point_t pending[$];
    int errors;

    function new();
      longint term;
      pole_lon = POLE_LON_RST;
      pole_lat = POLE_LAT_RST;
      errors = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (i == 0) begin
          atan_tab[i] = PI_Q60 >>> 2;
        end else begin
          atan_tab[i] = 0;
          for (int k = 0; i * (2 * k + 1) < 61; k++) begin
            term = ((64'sd1 <<< 60) >>> (i * (2 * k + 1))) / (2 * k + 1);
            atan_tab[i] += (k % 2 == 1) ? -term : term;
          end
        end
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_POLE_LON) pole_lon = $signed(data[POLE_LON_W-1:0]);
      else pole_lat = $signed(data[POLE_LAT_W-1:0]);
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function void sin_cos(longint deg, output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      bit neg;
      r = deg % DEG360;
      neg = 0;
      if (r < 0) r += DEG360;
      if (r >= DEG180) r -= DEG360;
      if (r > DEG90) begin
        r -= DEG180;
        neg = 1;
      end else if (r < -DEG90) begin
        r += DEG180;
        neg = 1;
      end
      z = r * D2R;
      x = KINV_Q30;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
    endfunction

    function longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q60 : -PI_Q60;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_tab[i];
        end else begin
          x -= dx; y += dy; z -= atan_tab[i];
        end
      end
      return z;
    endfunction

    function longint rad_to_deg(longint r);
      return ((r >>> 26) * R2D + (64'sd1 <<< 37)) >>> 38;
    endfunction

    function longint int_sqrt(bit [63:0] n);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void note(bit fwd, logic [LON_IN_W-1:0] lon_in, logic [LAT_IN_W-1:0] lat_in);
      longint lon, lat, d, l, sl, cl, sp, cp, sd, cd, v, c, xx, yy, lat_o, lon_o;
      point_t p;
      lon = $signed(lon_in);
      lat = $signed(lat_in);
      d = pole_lat - DEG90;
      l = lon;
      if (!fwd) begin
        l = lon - DEG180 - pole_lon;
        d = -d;
      end
      sin_cos(l, sl, cl);
      sin_cos(lat, sp, cp);
      sin_cos(d, sd, cd);
      v = mulq(cd, sp) - mulq(mulq(cl, sd), cp);
      if (v > ONE_Q30) v = ONE_Q30;
      if (v < -ONE_Q30) v = -ONE_Q30;
      c = int_sqrt((64'sd1 <<< 60) - v * v);
      lat_o = rad_to_deg(vector_angle(v, c));
      yy = mulq(sl, cp);
      xx = mulq(sp, sd) + mulq(mulq(cl, cd), cp);
      lon_o = rad_to_deg(vector_angle(yy, xx));
      if (fwd) lon_o += DEG180 + pole_lon;
      p.lon = lon_o[LON_OUT_W-1:0];
      p.lat = lat_o[LAT_OUT_W-1:0];
      pending.push_back(p);
    endfunction

    function void check(logic [LON_OUT_W-1:0] lon, logic [LAT_OUT_W-1:0] lat);
      point_t p;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result transaction lon %0d lat %0d",
                   $signed(lon), $signed(lat));
        return;
      end
      p = pending.pop_front();
      if (p.lon !== lon || p.lat !== lat) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected lon %0d lat %0d, got lon %0d lat %0d",
                   $signed(p.lon), $signed(p.lat), $signed(lon), $signed(lat));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rpct_in_if in_ch();
  rpct_out_if out_ch();

  rotated_pole_coordinate_transform_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  transform_scoreboard sb = new();
  int send_idle = 11;
  int recv_idle = 85;
  bit hold_req = 0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver with random stalls and a single long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check(out_ch.lon_out, out_ch.lat_out);
  end

  task automatic send_point(bit fwd, logic [LON_IN_W-1:0] lon, logic [LAT_IN_W-1:0] lat);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.forward <= fwd;
    in_ch.lon_in <= lon;
    in_ch.lat_in <= lat;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note(fwd, lon, lat);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [LON_IN_W-1:0] lon;
    logic [LAT_IN_W-1:0] lat;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        lon = LON_IN_W'($urandom());
        lat = LAT_IN_W'($urandom());
      end else begin
        lon = LON_IN_W'($urandom_range(0, 2 * DEG180) - DEG180);
        lat = LAT_IN_W'($urandom_range(0, 2 * DEG90) - DEG90);
      end
      send_point(1'($urandom_range(0, 1)), lon, lat);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] plon, plat;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_POLE_LON;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.forward = 1'b0;
    in_ch.lon_in = '0;
    in_ch.lat_in = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, poles, both directions, full-width bit patterns
    for (int f = 0; f < 2; f++) begin
      send_point(1'(f), LON_IN_W'(-DEG180), '0);
      send_point(1'(f), LON_IN_W'(DEG180), '0);
      send_point(1'(f), '0, LAT_IN_W'(DEG90));
      send_point(1'(f), '0, LAT_IN_W'(-DEG90));
      send_point(1'(f), '0, '0);
      send_point(1'(f), 25'h1000000, 24'h800000);
      send_point(1'(f), 25'h0ffffff, 24'h7fffff);
      send_point(1'(f), LON_IN_W'(POLE_LON_RST), POLE_LAT_RST);
      send_point(1'(f), LON_IN_W'(DEG90), LAT_IN_W'(DEG90 / 2));
      send_point(1'(f), LON_IN_W'(-DEG90), LAT_IN_W'(-DEG90 / 2));
    end
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin plon = POLE_LON_RST; plat = CFG_DATA_W'(POLE_LAT_RST); end
        1: begin plon = CFG_DATA_W'(DEG360); plat = CFG_DATA_W'(DEG90); end
        2: begin plon = CFG_DATA_W'(-DEG360); plat = CFG_DATA_W'(-DEG90); end
        3: begin
          plon = CFG_DATA_W'($urandom_range(0, 2 * DEG360) - DEG360);
          plat = CFG_DATA_W'($urandom_range(0, 2 * DEG90) - DEG90);
        end
        4: begin plon = CFG_DATA_W'($urandom()); plat = CFG_DATA_W'($urandom()); end
        default: begin plon = '0; plat = '0; end
      endcase
      write_reg(REG_POLE_LON, plon);
      write_reg(REG_POLE_LAT, plat);
      cfg_we_i <= 1'b0;
      if (seg < 2) begin
        send_idle = 11; recv_idle = 85;
      end else if (seg < 4) begin
        send_idle = 85; recv_idle = 11;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if (seg == 4) hold_req = 1;
      send_random(115);
      drain();
    end

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rpct_pkg.sv
rtl/rpct_if.sv
rtl/rpct_sincos.sv
rtl/rpct_isqrt.sv
rtl/rpct_atan2.sv
rtl/rotated_pole_coordinate_transform_unit.sv
rtl/rpct_checker.sv
tb/tb_top.sv
